FILE: hw/rtl/first_fit_coalescing_allocator_defines.svh
// Assertion macros for the first-fit coalescing allocator.
// Each macro is empty in synthesis.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define FFCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFCA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define FFCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Command and status codes and fixed port widths of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffca_pkg;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REQ_W    = 16;
  localparam int unsigned POFF_W   = 15;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned FREE_W   = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_REQ = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;
endpackage
`default_nettype wire

FILE: hw/rtl/ffca_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffca_hdr_ram
// Block header store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffca_hdr_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 33
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/first_fit_coalescing_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit heap allocator over an address-ordered free list with coalescing.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. cmd_i selects
// allocate (request_bytes_i) or free (payload_offset_i). The one result of
// each transaction appears on status_o, address_o and bytes_free_o for a
// single cycle while done_o is high; the receiver cannot hold it off, and
// busy_o stays high through that cycle.
// A rejected command goes straight to the result. An allocate walks the free
// list block by block, and a split allocate or a free adds an insertion walk
// over the blocks in front of the insertion point. The single header memory
// read port, one read per step of the list walk, sets the pace of both walks.
// After reset the block runs a clearing pass over the header memory, one
// entry a cycle (HEAP_BYTES / ALIGN_BYTES entries, 4096 by default), with
// busy_o high, then comes up with one free block spanning the heap.
`default_nettype none
`include "first_fit_coalescing_allocator_defines.svh"
module first_fit_coalescing_allocator #(
  parameter int unsigned HEAP_BYTES   = 32768,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cmd_i,
  input  wire logic [ffca_pkg::REQ_W-1:0]    request_bytes_i,
  input  wire logic [ffca_pkg::POFF_W-1:0]   payload_offset_i,
  output logic                               done_o,
  output logic [ffca_pkg::STATUS_W-1:0]      status_o,
  output logic [ffca_pkg::ADDR_W-1:0]        address_o,
  output logic [ffca_pkg::FREE_W-1:0]        bytes_free_o
);
  localparam int unsigned DEPTH = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned AW    = $clog2(ALIGN_BYTES);
  localparam int unsigned OW    = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned CW    = ((OW > 17) ? OW : 17) + 1;
  localparam int unsigned HW    = 2 * OW + 1;
  localparam int unsigned SW    = IW + 1;

  localparam logic [CW-1:0] END_OFF   = CW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] MIN_SPLIT = CW'(2 * HEADER_BYTES);
  localparam logic [CW-1:0] HDR_C     = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] RND_C     = CW'(HEADER_BYTES + ALIGN_BYTES - 1);
  localparam logic [CW-1:0] ALN_MASK  = CW'(ALIGN_BYTES - 1);
  localparam logic [IW-1:0] END_IDX   = END_OFF[AW +: IW];

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_A_RD      = 5'd2;
  localparam logic [4:0] S_A_CHK     = 5'd3;
  localparam logic [4:0] S_A_UNLINK  = 5'd4;
  localparam logic [4:0] S_A_WRBLK   = 5'd5;
  localparam logic [4:0] S_F_RD      = 5'd6;
  localparam logic [4:0] S_F_CHK     = 5'd7;
  localparam logic [4:0] S_I_START   = 5'd8;
  localparam logic [4:0] S_I_WALK    = 5'd9;
  localparam logic [4:0] S_I_WCHK    = 5'd10;
  localparam logic [4:0] S_I_MPREV   = 5'd11;
  localparam logic [4:0] S_I_MNEXT   = 5'd12;
  localparam logic [4:0] S_I_NXCHK   = 5'd13;
  localparam logic [4:0] S_I_WRBLK   = 5'd14;
  localparam logic [4:0] S_I_LINK    = 5'd15;
  localparam logic [4:0] S_DONE      = 5'd16;

  logic [4:0]    state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [CW-1:0] need_q, need_d;
  logic [CW-1:0] blk_q, blk_d, bsz_q, bsz_d, bnx_q, bnx_d;
  logic          bal_q, bal_d;
  logic [CW-1:0] it_q, it_d, itsz_q, itsz_d, itnx_q, itnx_d;
  logic          ital_q, ital_d, itdum_q, itdum_d, merged_q, merged_d;
  logic [CW-1:0] nx_q, nx_d, head_q, head_d, free_q, free_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [ffca_pkg::STATUS_W-1:0] status_q, status_d;
  logic [ffca_pkg::ADDR_W-1:0]   addr_q, addr_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata;
  logic [CW-1:0] rsz, rnx;
  logic          ral;
  logic [CW-1:0] req_need, poff_ext, hpos, rem, gsz;
  logic          split;

  ffca_hdr_ram #(.DEPTH(DEPTH), .WIDTH(HW)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Header word layout: {alloc, next, size}.
  assign rsz = CW'(rdata[OW-1:0]);
  assign rnx = CW'(rdata[2*OW-1:OW]);
  assign ral = rdata[HW-1];

  assign req_need = (CW'(request_bytes_i) + RND_C) & ~ALN_MASK;
  assign poff_ext = CW'(payload_offset_i);
  assign hpos     = poff_ext - HDR_C;
  assign rem      = bsz_q - need_q;
  assign split    = rem > MIN_SPLIT;
  assign gsz      = split ? need_q : bsz_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    need_d   = need_q;
    blk_d    = blk_q;
    bsz_d    = bsz_q;
    bnx_d    = bnx_q;
    bal_d    = bal_q;
    it_d     = it_q;
    itsz_d   = itsz_q;
    itnx_d   = itnx_q;
    ital_d   = ital_q;
    itdum_d  = itdum_q;
    merged_d = merged_q;
    nx_d     = nx_q;
    head_d   = head_q;
    free_d   = free_q;
    steps_d  = steps_q;
    status_d = status_q;
    addr_d   = addr_q;
    we       = 1'b0;
    waddr    = blk_q[AW +: IW];
    wdata    = '0;
    raddr    = blk_q[AW +: IW];

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == '0) begin
          wdata = {1'b0, OW'(END_OFF), OW'(END_OFF)};
        end else if (clr_q == END_IDX) begin
          wdata = {1'b0, OW'(END_OFF), {OW{1'b0}}};
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == IW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          status_d = ffca_pkg::ST_OK;
          addr_d   = '0;
          steps_d  = '0;
          itdum_d  = 1'b1;
          merged_d = 1'b0;
          need_d   = req_need;
          if (cmd_i == ffca_pkg::CMD_ALLOC) begin
            blk_d = head_q;
            if (request_bytes_i == '0) begin
              status_d = ffca_pkg::ST_ZERO_REQ;
              state_d  = S_DONE;
            end else if (req_need > free_q) begin
              status_d = ffca_pkg::ST_NO_SPACE;
              state_d  = S_DONE;
            end else begin
              state_d = S_A_RD;
            end
          end else begin
            blk_d = hpos;
            if (poff_ext < HDR_C || (hpos & ALN_MASK) != '0 || hpos >= END_OFF) begin
              status_d = ffca_pkg::ST_BAD_FREE;
              state_d  = S_DONE;
            end else begin
              state_d = S_F_RD;
            end
          end
        end
      end
      S_A_RD: begin
        if (blk_q == END_OFF) begin
          status_d = ffca_pkg::ST_NO_SPACE;
          state_d  = S_DONE;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (rsz >= need_q) begin
          bsz_d   = rsz;
          bnx_d   = rnx;
          state_d = S_A_UNLINK;
        end else if (steps_q == SW'(DEPTH)) begin
          status_d = ffca_pkg::ST_NO_SPACE;
          state_d  = S_DONE;
        end else begin
          it_d    = blk_q;
          itsz_d  = rsz;
          itnx_d  = rnx;
          ital_d  = ral;
          itdum_d = 1'b0;
          blk_d   = rnx;
          steps_d = steps_q + 1'b1;
          state_d = S_A_RD;
        end
      end
      S_A_UNLINK: begin
        if (itdum_q) begin
          head_d = bnx_q;
        end else begin
          we    = 1'b1;
          waddr = it_q[AW +: IW];
          wdata = {ital_q, OW'(bnx_q), OW'(itsz_q)};
        end
        state_d = S_A_WRBLK;
      end
      S_A_WRBLK: begin
        we     = 1'b1;
        wdata  = {1'b1, {OW{1'b0}}, OW'(gsz)};
        free_d = free_q - gsz;
        addr_d = ffca_pkg::ADDR_W'(blk_q + HDR_C);
        if (split) begin
          blk_d   = blk_q + need_q;
          bsz_d   = rem;
          state_d = S_I_START;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_RD: begin
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (!ral) begin
          status_d = ffca_pkg::ST_BAD_FREE;
          state_d  = S_DONE;
        end else begin
          free_d  = free_q + rsz;
          bsz_d   = rsz;
          state_d = S_I_START;
        end
      end
      S_I_START: begin
        bal_d   = 1'b0;
        itdum_d = 1'b1;
        nx_d    = head_q;
        steps_d = '0;
        state_d = S_I_WALK;
      end
      S_I_WALK: begin
        raddr = nx_q[AW +: IW];
        if (nx_q < blk_q && steps_q != SW'(DEPTH)) begin
          it_d    = nx_q;
          itdum_d = 1'b0;
          steps_d = steps_q + 1'b1;
          state_d = S_I_WCHK;
        end else begin
          state_d = S_I_MPREV;
        end
      end
      S_I_WCHK: begin
        itsz_d  = rsz;
        itnx_d  = rnx;
        ital_d  = ral;
        nx_d    = rnx;
        state_d = S_I_WALK;
      end
      S_I_MPREV: begin
        // The block touches the free block in front of it: absorb it there.
        if (!itdum_q && it_q + itsz_q == blk_q) begin
          we       = 1'b1;
          wdata    = '0;
          bsz_d    = itsz_q + bsz_q;
          bnx_d    = itnx_q;
          bal_d    = ital_q;
          blk_d    = it_q;
          merged_d = 1'b1;
        end
        state_d = S_I_MNEXT;
      end
      S_I_MNEXT: begin
        raddr = nx_q[AW +: IW];
        if (blk_q + bsz_q == nx_q) begin
          if (nx_q != END_OFF) begin
            state_d = S_I_NXCHK;
          end else begin
            bnx_d   = END_OFF;
            state_d = S_I_WRBLK;
          end
        end else begin
          bnx_d   = nx_q;
          state_d = S_I_WRBLK;
        end
      end
      S_I_NXCHK: begin
        we      = 1'b1;
        waddr   = nx_q[AW +: IW];
        wdata   = '0;
        bsz_d   = bsz_q + rsz;
        bnx_d   = rnx;
        state_d = S_I_WRBLK;
      end
      S_I_WRBLK: begin
        we      = 1'b1;
        wdata   = {bal_q, OW'(bnx_q), OW'(bsz_q)};
        state_d = S_I_LINK;
      end
      S_I_LINK: begin
        if (!merged_q) begin
          if (itdum_q) begin
            head_d = blk_q;
          end else begin
            we    = 1'b1;
            waddr = it_q[AW +: IW];
            wdata = {ital_q, OW'(blk_q), OW'(itsz_q)};
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      need_q   <= '0;
      blk_q    <= '0;
      bsz_q    <= '0;
      bnx_q    <= '0;
      bal_q    <= 1'b0;
      it_q     <= '0;
      itsz_q   <= '0;
      itnx_q   <= '0;
      ital_q   <= 1'b0;
      itdum_q  <= 1'b1;
      merged_q <= 1'b0;
      nx_q     <= '0;
      head_q   <= '0;
      free_q   <= END_OFF;
      steps_q  <= '0;
      status_q <= ffca_pkg::ST_OK;
      addr_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      need_q   <= need_d;
      blk_q    <= blk_d;
      bsz_q    <= bsz_d;
      bnx_q    <= bnx_d;
      bal_q    <= bal_d;
      it_q     <= it_d;
      itsz_q   <= itsz_d;
      itnx_q   <= itnx_d;
      ital_q   <= ital_d;
      itdum_q  <= itdum_d;
      merged_q <= merged_d;
      nx_q     <= nx_d;
      head_q   <= head_d;
      free_q   <= free_d;
      steps_q  <= steps_d;
      status_q <= status_d;
      addr_q   <= addr_d;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign status_o     = status_q;
  assign address_o    = addr_q;
  assign bytes_free_o = ffca_pkg::FREE_W'(free_q);

  `FFCA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o,
    "Accepted command did not raise busy")
  `FFCA_ASSERT_SAME(a_addr_zero, clk_i, rst_ni, done_o && (status_o != ffca_pkg::ST_OK),
    address_o == '0, "Failed command returned a nonzero address")
  `FFCA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o && !busy_o,
    "Result strobe longer than one cycle")
  `FFCA_ASSERT_SAME(a_free_range, clk_i, rst_ni, 1'b1, free_q <= END_OFF,
    "Free byte count exceeds heap size")
endmodule
`default_nettype wire
